@@ hw/rtl/b64c_pkg.sv @@
// Shared types, constants and alphabet functions for the base64 stream codec.
package b64c_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// One unit of back-end work: a full or partial group, or an error marker
	typedef struct packed {
		logic [23:0] triple;
		logic        enc;
		logic        err;
		logic [1:0]  cnt_m1;
		logic [1:0]  npad;
		logic        last;
	} job_t;

	// Returns {invalid, sextet}; an invalid character yields sextet zero
	function automatic logic [6:0] sextet_of(logic [7:0] c);
		logic [6:0] r;
		case (c) inside
			[8'h41:8'h5A]: r = {1'b0, 6'(c - 8'h41)};
			[8'h61:8'h7A]: r = {1'b0, 6'(c - 8'h47)};
			[8'h30:8'h39]: r = {1'b0, 6'(c + 8'h04)};
			8'h2B:         r = {1'b0, 6'd62};
			8'h2F:         r = {1'b0, 6'd63};
			default:       r = {1'b1, 6'd0};
		endcase
		return r;
	endfunction

	function automatic logic [7:0] char_of(logic [5:0] s);
		logic [7:0] r;
		case (s) inside
			[6'd0:6'd25]:  r = {2'b00, s} + 8'h41;
			[6'd26:6'd51]: r = {2'b00, s} + 8'h47;
			[6'd52:6'd61]: r = {2'b00, s} - 8'h04;
			6'd62:         r = 8'h2B;
			default:       r = 8'h2F;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/base64_stream_codec.sv @@
// Base64 stream codec: direction register 0 encodes bytes into base64 text, 1 decodes text
// into bytes. An input word is taken in any cycle in which the job queue has room, so
// decoding runs at one word per cycle; the back end delivers one result word per cycle
// while out_ready is high and a job is waiting, so encoding (four characters per three
// bytes) is paced by the output. A result passes through the job queue, the job register
// and the output register. Malformed decode input gives one error word (out_error and
// out_last set, out_byte zero) and the rest of that message is dropped. Write the direction
// only while the codec is idle; each write starts a new message.
module base64_stream_codec #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       out_error,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_direction
);
	import b64c_pkg::*;

	logic q_ready;
	logic q_valid;
	logic push;
	logic pop;
	job_t push_job;
	job_t q_head;

	assign cfg_ready = 1'b1;

	b64c_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.in_last       (in_last),
		.cfg_valid     (cfg_valid),
		.cfg_direction (cfg_direction),
		.q_ready       (q_ready),
		.push          (push),
		.push_job      (push_job)
	);

	b64c_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.ready    (q_ready),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	b64c_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.out_error (out_error)
	);

endmodule

@@ hw/rtl/b64c_front.sv @@
// Front end: accepts words, gathers groups and classifies them into jobs.
module b64c_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	input  logic          cfg_valid,
	input  logic          cfg_direction,
	input  logic          q_ready,
	output logic          push,
	output b64c_pkg::job_t push_job
);
	import b64c_pkg::*;

	logic        dir_q;
	logic [17:0] held_q, held_d;
	logic [1:0]  cnt_q, cnt_d;
	logic        tp_q, tp_d;
	logic        abs_q, abs_d;
	logic        accept;
	logic        job_d;
	logic [6:0]  sx;
	logic        bad;
	logic        pad;
	logic [5:0]  vz;
	logic [1:0]  trim;

	assign in_ready = q_ready;
	assign accept   = in_valid && q_ready;
	assign sx       = sextet_of(in_byte);
	assign bad      = sx[6];
	assign pad      = (in_byte == PAD_CHAR);
	assign vz       = pad ? 6'd0 : sx[5:0];
	assign trim     = in_last ? ({1'b0, tp_q} + {1'b0, pad}) : 2'd0;

	always_comb begin
		job_d           = 1'b0;
		push_job        = '0;
		held_d          = held_q;
		cnt_d           = cnt_q;
		tp_d            = tp_q;
		abs_d           = abs_q;
		if (dir_q) begin
			push_job.enc = 1'b0;
			if (abs_q) begin
				// drop everything through the end of the bad message
				if (in_last) begin
					abs_d = 1'b0;
				end
			end else if ((bad && !(cnt_q[1] && pad)) || (cnt_q != 2'd3 && in_last)) begin
				job_d         = 1'b1;
				push_job.err  = 1'b1;
				push_job.last = 1'b1;
				held_d        = '0;
				cnt_d         = '0;
				tp_d          = 1'b0;
				abs_d         = !in_last;
			end else if (cnt_q != 2'd3) begin
				held_d = {held_q[11:0], vz};
				if (cnt_q == 2'd2) begin
					tp_d = pad;
				end
				cnt_d = cnt_q + 2'd1;
			end else begin
				job_d           = 1'b1;
				push_job.triple = {held_q, vz};
				push_job.cnt_m1 = 2'd2 - trim;
				push_job.last   = in_last;
				held_d          = '0;
				cnt_d           = '0;
				tp_d            = 1'b0;
			end
		end else begin
			push_job.enc = 1'b1;
			if (!cnt_q[1] && !in_last) begin
				held_d = {held_q[9:0], in_byte};
				cnt_d  = cnt_q + 2'd1;
			end else begin
				job_d           = 1'b1;
				push_job.cnt_m1 = 2'd3;
				push_job.last   = in_last;
				case (cnt_q)
					2'd0: begin
						push_job.triple = {in_byte, 16'h0000};
						push_job.npad   = 2'd2;
					end
					2'd1: begin
						push_job.triple = {held_q[7:0], in_byte, 8'h00};
						push_job.npad   = 2'd1;
					end
					default: begin
						push_job.triple = {held_q[15:0], in_byte};
						push_job.npad   = 2'd0;
					end
				endcase
				held_d = '0;
				cnt_d  = '0;
			end
		end
	end

	assign push = accept && job_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= 1'b0;
			held_q <= '0;
			cnt_q  <= '0;
			tp_q   <= 1'b0;
			abs_q  <= 1'b0;
		end else if (cfg_valid) begin
			// new direction starts a fresh message
			dir_q  <= cfg_direction;
			held_q <= '0;
			cnt_q  <= '0;
			tp_q   <= 1'b0;
			abs_q  <= 1'b0;
		end else if (accept) begin
			held_q <= held_d;
			cnt_q  <= cnt_d;
			tp_q   <= tp_d;
			abs_q  <= abs_d;
		end
	end

endmodule

@@ hw/rtl/b64c_queue.sv @@
// Small job queue between the front and back ends.
module b64c_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64c_pkg::job_t push_job,
	output logic           ready,
	input  logic           pop,
	output logic           valid,
	output b64c_pkg::job_t head
);
	import b64c_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	job_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] count_q;

	assign ready = (count_q != CntW'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) push |-> count_q != CntW'(DEPTH))
		else $error("job queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> count_q != '0)
		else $error("job queue underflow");
`endif

endmodule

@@ hw/rtl/b64c_back.sv @@
// Back end: expands each job into result words, one per cycle while out_ready allows.
module b64c_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  b64c_pkg::job_t q_head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           out_last,
	output logic           out_error
);
	import b64c_pkg::*;

	job_t       job_q;
	logic       job_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_error_q;
	logic       advance;
	logic       emit;
	logic       job_done;
	logic [5:0] sextet;
	logic [7:0] dec_byte;
	logic [7:0] res_byte;
	logic       res_last;
	logic       res_error;

	assign advance  = !out_valid_q || out_ready;
	assign emit     = advance && job_valid_q;
	assign job_done = emit && (idx_q == job_q.cnt_m1);
	assign pop      = q_valid && (!job_valid_q || job_done);

	always_comb begin
		case (idx_q)
			2'd0:    sextet = job_q.triple[23:18];
			2'd1:    sextet = job_q.triple[17:12];
			2'd2:    sextet = job_q.triple[11:6];
			default: sextet = job_q.triple[5:0];
		endcase
		case (idx_q)
			2'd0:    dec_byte = job_q.triple[23:16];
			2'd1:    dec_byte = job_q.triple[15:8];
			default: dec_byte = job_q.triple[7:0];
		endcase
		if (job_q.err) begin
			res_byte  = 8'h00;
			res_last  = 1'b1;
			res_error = 1'b1;
		end else if (job_q.enc) begin
			// trailing positions of a short group become pad characters
			res_byte  = (({1'b0, idx_q} + {1'b0, job_q.npad}) > 3'd3) ? PAD_CHAR
				: char_of(sextet);
			res_last  = job_q.last && (idx_q == 2'd3);
			res_error = 1'b0;
		end else begin
			res_byte  = dec_byte;
			res_last  = job_q.last && (idx_q == job_q.cnt_m1);
			res_error = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_head;
		end
		if (emit) begin
			out_byte_q  <= res_byte;
			out_last_q  <= res_last;
			out_error_q <= res_error;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= job_valid_q;
			end
			if (pop) begin
				job_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (job_done) begin
				job_valid_q <= 1'b0;
				idx_q       <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_error = out_error_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error |-> out_last && out_byte == 8'h00)
		else $error("error word must be final and zero");
	assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> idx_q <= job_q.cnt_m1)
		else $error("result index ran past job length");
`endif

endmodule

@@ test/base64_stream_codec_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_codec: a directed table, then random messages in both directions.
module base64_stream_codec_tb;
	import b64c_pkg::*;

	localparam logic       DIR_ENCODE      = 1'b0;
	localparam logic       DIR_DECODE      = 1'b1;
	localparam logic [6:0] NO_SEXTET       = 7'h40;
	localparam int         SETTLE_CYCLES   = 12;
	localparam int         HOLD_OFF_CYCLES = 300;
	localparam int         PHASE_ITEMS     = 72;
	localparam int         NUM_PHASES      = 6;
	localparam int         DRAIN_LIMIT     = 5000;
	localparam int         CYCLE_LIMIT     = 200000;
	localparam int         NUM_ROWS        = 24;

	localparam logic PHASE_DIR [NUM_PHASES] = '{DIR_ENCODE, DIR_DECODE, DIR_ENCODE,
		DIR_DECODE, DIR_DECODE, DIR_ENCODE};

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} codec_word_t;

	typedef struct packed {
		logic            dir;
		logic [7:0]      data;
		logic            last;
		logic            typed;
		logic [2:0]      count;
		logic [0:3][7:0] chars;
		logic            err;
	} stim_row_t;

	// typed rows carry their own expected words; the rest go through the predictor
	localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
		'{DIR_ENCODE, 8'h00, 1'b1, 1'b1, 3'd4, 32'h41413D3D, 1'b0},
		'{DIR_ENCODE, 8'hFF, 1'b0, 1'b1, 3'd0, 32'h0, 1'b0},
		'{DIR_ENCODE, 8'hFF, 1'b1, 1'b1, 3'd4, 32'h2F2F383D, 1'b0},
		'{DIR_ENCODE, 8'h00, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		'{DIR_ENCODE, 8'h00, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		'{DIR_ENCODE, 8'h00, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		'{DIR_ENCODE, 8'hFF, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		'{DIR_ENCODE, 8'hFF, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		'{DIR_ENCODE, 8'hFF, 1'b1, 1'b1, 3'd4, 32'h2F2F2F2F, 1'b0},
		// pad in a group that is not final
		'{DIR_DECODE, 8'h41, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		'{DIR_DECODE, 8'h42, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		'{DIR_DECODE, PAD_CHAR, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		'{DIR_DECODE, PAD_CHAR, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		// pad in third place only, final group
		'{DIR_DECODE, 8'h41, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		'{DIR_DECODE, 8'h42, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		'{DIR_DECODE, PAD_CHAR, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		'{DIR_DECODE, 8'h43, 1'b1, 1'b0, 3'd0, 32'h0, 1'b0},
		// early pad, then the rest of the message is dropped
		'{DIR_DECODE, 8'h41, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		'{DIR_DECODE, PAD_CHAR, 1'b0, 1'b1, 3'd1, 32'h0, 1'b1},
		'{DIR_DECODE, 8'h5A, 1'b1, 1'b1, 3'd0, 32'h0, 1'b0},
		// bad length
		'{DIR_DECODE, 8'h41, 1'b0, 1'b0, 3'd0, 32'h0, 1'b0},
		'{DIR_DECODE, 8'h42, 1'b1, 1'b1, 3'd1, 32'h0, 1'b1},
		// NUL and top byte are invalid characters
		'{DIR_DECODE, 8'h00, 1'b1, 1'b1, 3'd1, 32'h0, 1'b1},
		'{DIR_DECODE, 8'hFF, 1'b1, 1'b1, 3'd1, 32'h0, 1'b1}
	};

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte       = 8'h00;
	logic       in_last       = 1'b0;
	logic       out_valid;
	logic       out_ready     = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;
	logic       out_error;
	logic       cfg_valid     = 1'b0;
	logic       cfg_ready;
	logic       cfg_direction = 1'b0;

	string       b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	logic [6:0]  sextet_lut [256];
	codec_word_t pending_words [$];
	codec_word_t model_words [4];
	logic [7:0]  msg_bytes [$];
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          stall_left     = 0;
	logic        idle_on        = 1'b1;
	logic        hold_off_req   = 1'b0;

	// predictor state
	logic        dir_q       = DIR_ENCODE;
	logic [17:0] held_q      = '0;
	logic [1:0]  fill_q      = '0;
	logic        third_pad_q = 1'b0;
	logic        absorb_q    = 1'b0;

	base64_stream_codec dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.in_last      (in_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.out_last     (out_last),
		.out_error    (out_error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_direction(cfg_direction)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("base64_stream_codec_tb: done, errors");
			$finish;
		end
	end

	function automatic logic [7:0] enc_char(logic [5:0] s);
		return b64_alphabet[s];
	endfunction

	task automatic clear_group();
		held_q      = '0;
		fill_q      = '0;
		third_pad_q = 1'b0;
		absorb_q    = 1'b0;
	endtask

	task automatic codec_predict(input logic [7:0] b, input logic l, output int n);
		logic [23:0] triple;
		logic [6:0]  sx;
		logic        pad;
		int          keep;
		n = 0;
		if (dir_q == DIR_ENCODE) begin
			if (fill_q < 2'd2 && !l) begin
				held_q = {held_q[9:0], b};
				fill_q = fill_q + 2'd1;
			end else begin
				case (fill_q)
					2'd0: triple = {b, 16'h0000};
					2'd1: triple = {held_q[7:0], b, 8'h00};
					default: triple = {held_q[15:0], b};
				endcase
				model_words[0] = '{enc_char(triple[23:18]), 1'b0, 1'b0};
				model_words[1] = '{enc_char(triple[17:12]), 1'b0, 1'b0};
				if (fill_q == 2'd0)
					model_words[2] = '{PAD_CHAR, 1'b0, 1'b0};
				else
					model_words[2] = '{enc_char(triple[11:6]), 1'b0, 1'b0};
				if (fill_q == 2'd2)
					model_words[3] = '{enc_char(triple[5:0]), l, 1'b0};
				else
					model_words[3] = '{PAD_CHAR, 1'b1, 1'b0};
				n = 4;
				clear_group();
			end
		end else if (absorb_q) begin
			if (l)
				absorb_q = 1'b0;
		end else begin
			pad = (b == PAD_CHAR);
			sx  = sextet_lut[b];
			// invalid character, or a last word that leaves the group open
			if ((sx == NO_SEXTET && !(fill_q >= 2'd2 && pad)) || (fill_q < 2'd3 && l)) begin
				clear_group();
				absorb_q       = !l;
				model_words[0] = '{8'h00, 1'b1, 1'b1};
				n = 1;
			end else begin
				if (pad)
					sx = 7'h00;
				if (fill_q < 2'd3) begin
					held_q = {held_q[11:0], sx[5:0]};
					if (fill_q == 2'd2)
						third_pad_q = pad;
					fill_q = fill_q + 2'd1;
				end else begin
					triple = {held_q, sx[5:0]};
					keep   = 3;
					if (l)
						keep = keep - int'(third_pad_q) - int'(pad);
					for (int i = 0; i < keep; i++)
						model_words[i] = '{triple[23 - 8 * i -: 8], l && (i == keep - 1), 1'b0};
					n = keep;
					clear_group();
				end
			end
		end
	endtask

	task automatic send_word(input logic [7:0] b, input logic l, input logic from_model);
		int n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= l;
		do @(posedge clk); while (!in_ready);
		codec_predict(b, l, n);
		if (from_model)
			for (int i = 0; i < n; i++)
				pending_words.push_back(model_words[i]);
	endtask

	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		// let dropped words finish inside the block
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_direction(input logic d);
		settle_idle();
		cfg_valid     <= 1'b1;
		cfg_direction <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dir_q = d;
		clear_group();
	endtask

	task automatic build_bytes();
		msg_bytes.delete();
		repeat ($urandom_range(1, 12)) begin
			if ($urandom_range(0, 7) == 0)
				msg_bytes.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
			else
				msg_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic build_text();
		int groups;
		int tail;
		int noise;
		int len;
		msg_bytes.delete();
		groups = $urandom_range(1, 4);
		repeat (4 * groups)
			msg_bytes.push_back(b64_alphabet[$urandom_range(0, 63)]);
		len  = msg_bytes.size();
		tail = $urandom_range(0, 3);
		if (tail == 1) begin
			msg_bytes[len - 2] = PAD_CHAR;
			msg_bytes[len - 1] = PAD_CHAR;
		end else if (tail == 2) begin
			msg_bytes[len - 1] = PAD_CHAR;
		end else if (tail == 3) begin
			msg_bytes[len - 2] = PAD_CHAR;
		end
		if (groups > 1 && $urandom_range(0, 3) == 0)
			msg_bytes[4 * $urandom_range(0, groups - 2) + $urandom_range(2, 3)] = PAD_CHAR;
		// corrupt a few messages
		noise = $urandom_range(0, 9);
		if (noise == 0) begin
			msg_bytes[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
		end else if (noise == 1) begin
			repeat ($urandom_range(1, 3))
				void'(msg_bytes.pop_back());
		end else if (noise == 2) begin
			msg_bytes[4 * $urandom_range(0, groups - 1) + $urandom_range(0, 1)] = PAD_CHAR;
		end
	endtask

	always @(posedge clk) begin
		codec_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected word: out_byte=%h out_last=%b out_error=%b",
					out_byte, out_last, out_error);
				mismatch_count++;
			end else begin
				want = pending_words.pop_front();
				if (out_byte !== want.data) begin
					$error("out_byte: expected %h, got %h", want.data, out_byte);
					mismatch_count++;
				end
				if (out_last !== want.last) begin
					$error("out_last: expected %b, got %b", want.last, out_last);
					mismatch_count++;
				end
				if (out_error !== want.err) begin
					$error("out_error: expected %b, got %b", want.err, out_error);
					mismatch_count++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (hold_off_req) begin
			// hold off long enough for the block to fill and stall its input
			hold_off_req = 1'b0;
			stall_left   = HOLD_OFF_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		int sent;
		int waited;
		int k;
		for (int c = 0; c < 256; c++)
			sextet_lut[c] = NO_SEXTET;
		for (int s = 0; s < 64; s++)
			sextet_lut[b64_alphabet[s]] = 7'(s);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part starts in the reset direction
		foreach (DIR_ROWS[r]) begin
			if (DIR_ROWS[r].dir != dir_q)
				write_direction(DIR_ROWS[r].dir);
			send_word(DIR_ROWS[r].data, DIR_ROWS[r].last, !DIR_ROWS[r].typed);
			if (DIR_ROWS[r].typed)
				for (int i = 0; i < DIR_ROWS[r].count; i++)
					pending_words.push_back('{DIR_ROWS[r].chars[i],
						(i == DIR_ROWS[r].count - 1) && (DIR_ROWS[r].last || DIR_ROWS[r].err),
						DIR_ROWS[r].err});
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			idle_on = (ph != NUM_PHASES - 1);
			write_direction(PHASE_DIR[ph]);
			if (ph == 2)
				hold_off_req = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (dir_q == DIR_ENCODE)
					build_bytes();
				else
					build_text();
				// the phase may end inside a message; the next write starts afresh
				for (k = 0; k < msg_bytes.size() && sent < PHASE_ITEMS; k++) begin
					send_word(msg_bytes[k], k == msg_bytes.size() - 1, 1'b1);
					sent++;
				end
			end
		end

		in_valid <= 1'b0;
		waited = 0;
		while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_words.size() != 0) begin
			$error("%0d expected words never arrived", pending_words.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("base64_stream_codec_tb: done, clean");
		else
			$display("base64_stream_codec_tb: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/b64c_pkg.sv
hw/rtl/b64c_front.sv
hw/rtl/b64c_queue.sv
hw/rtl/b64c_back.sv
hw/rtl/base64_stream_codec.sv
test/base64_stream_codec_tb.sv
